// File: rtl/core/sshd_pkg.sv
// types and constants shared by the swept sphere hit distance pipeline
// depends on nothing
package sshd_pkg;

   localparam int FRONT_STAGES = 7;                              // products through radicand select
   localparam int ROOT_STAGES  = 16;                             // two root steps per stage
   localparam int NUM_STAGES   = FRONT_STAGES + ROOT_STAGES + 1; // plus output register
   localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

   // per item control and values that ride along the pipe
   typedef struct packed {
      logic        use_static;
      logic        dyn_hit;
      logic [32:0] pq;
      logic [30:0] move;
      logic [31:0] radsum;
      logic        report;
   } sshd_side_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
   } sshd_root_type;

   // one digit step of the bit by bit square root
   function automatic sshd_root_type root_step(input sshd_root_type cur,
                                               input logic [63:0] bitv);
      sshd_root_type nxt;
      logic [63:0]   trial;
      trial = cur.root + bitv;
      if (cur.rem >= trial) begin
         nxt.rem  = cur.rem - trial;
         nxt.root = (cur.root >> 1) + bitv;
      end else begin
         nxt.rem  = cur.rem;
         nxt.root = cur.root >> 1;
      end
      return nxt;
   endfunction

endpackage

// File: rtl/core/swept_sphere_hit_distance.sv
// swept sphere against sphere hit test, Q16.16 fixed point, one beat per cycle when not stalled
// req beat to rsp beat through every stage register; throughput one beat per cycle unless rsp_stall holds it
// seven front stages (products, sums, range test, perpendicular, squares, distance,
// radicand), sixteen root stages (two square root steps each) and the output register
// every stage advances when it or the one after it can; stalls hold, bubbles fill
// synchronous active high reset clears all valid bits; payload is not reset
module swept_sphere_hit_distance
   import sshd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_offset_x,
   input  logic signed [31:0] req_offset_y,
   input  logic signed [31:0] req_offset_z,
   input  logic signed [17:0] req_dir_x,
   input  logic signed [17:0] req_dir_y,
   input  logic signed [17:0] req_dir_z,
   input  logic [30:0]        req_move_distance,
   input  logic [30:0]        req_mover_radius,
   input  logic [30:0]        req_target_radius,
   input  logic               req_check_at_start,
   input  logic               req_report_overlap_distance,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [30:0]        rsp_hit_distance
);

   // pipeline control: valid bits and per stage advance
   logic [NUM_STAGES-1:0] valid_ff, valid_in, adv;

   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (adv[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // stage 0: dot products terms, offset squares, radius sum
   logic signed [31:0] o_w [3];
   logic signed [17:0] d_w [3];
   logic signed [49:0] s0_prod_in [3];
   logic signed [63:0] s0_osq_in [3];
   logic signed [49:0] s0_prod_ff [3];
   logic [63:0]        s0_osq_ff [3];
   logic signed [31:0] s0_o_ff [3];
   logic signed [17:0] s0_d_ff [3];
   logic               s0_cas_ff;
   sshd_side_type      s0_side_in, s0_side_ff;

   always_comb begin
      o_w[0] = req_offset_x;
      o_w[1] = req_offset_y;
      o_w[2] = req_offset_z;
      d_w[0] = req_dir_x;
      d_w[1] = req_dir_y;
      d_w[2] = req_dir_z;
      for (int i = 0; i < 3; i++) begin
         s0_prod_in[i] = d_w[i] * o_w[i];
         s0_osq_in[i]  = o_w[i] * o_w[i];
      end
      s0_side_in.use_static = 1'b0;
      s0_side_in.dyn_hit    = 1'b0;
      s0_side_in.pq         = '0;
      s0_side_in.move       = req_move_distance;
      s0_side_in.radsum     = {1'b0, req_mover_radius} + {1'b0, req_target_radius};
      s0_side_in.report     = req_report_overlap_distance;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int i = 0; i < 3; i++) begin
            s0_prod_ff[i] <= s0_prod_in[i];
            s0_osq_ff[i]  <= s0_osq_in[i];
            s0_o_ff[i]    <= o_w[i];
            s0_d_ff[i]    <= d_w[i];
         end
         s0_cas_ff  <= req_check_at_start;
         s0_side_ff <= s0_side_in;
      end
   end

   // stage 1: projection, squared length, squared radius sum, reach limit
   logic signed [51:0] s1_p_in, s1_p_ff;
   logic [63:0]        s1_s_in, s1_s_ff;
   logic [63:0]        s1_rr_in, s1_rr_ff;
   logic [32:0]        s1_lim_in, s1_lim_ff;
   logic signed [31:0] s1_o_ff [3];
   logic signed [17:0] s1_d_ff [3];
   logic               s1_cas_ff;
   sshd_side_type      s1_side_ff;

   always_comb begin
      s1_p_in   = 52'(s0_prod_ff[0]) + 52'(s0_prod_ff[1]) + 52'(s0_prod_ff[2]);
      s1_s_in   = s0_osq_ff[0] + s0_osq_ff[1] + s0_osq_ff[2];
      s1_rr_in  = s0_side_ff.radsum * s0_side_ff.radsum;
      s1_lim_in = {1'b0, s0_side_ff.radsum} + {2'b0, s0_side_ff.move};
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_p_ff    <= s1_p_in;
         s1_s_ff    <= s1_s_in;
         s1_rr_ff   <= s1_rr_in;
         s1_lim_ff  <= s1_lim_in;
         s1_o_ff    <= s0_o_ff;
         s1_d_ff    <= s0_d_ff;
         s1_cas_ff  <= s0_cas_ff;
         s1_side_ff <= s0_side_ff;
      end
   end

   // stage 2: range test picks static or swept test; dir times projection
   logic               s2_bad_w;
   logic               s2_zero_w;
   logic [32:0]        s2_pq_w;
   logic signed [51:0] s2_dp_in [3];
   logic signed [51:0] s2_dp_ff [3];
   logic signed [31:0] s2_o_ff [3];
   logic [63:0]        s2_s_ff, s2_rr_ff;
   sshd_side_type      s2_side_in, s2_side_ff;

   always_comb begin
      s2_bad_w  = s1_p_ff[51] || (s1_p_ff[50:0] > {2'b0, s1_lim_ff, 16'b0});
      s2_zero_w = (s1_side_ff.move == '0);
      s2_pq_w   = s1_p_ff[48:16];
      for (int i = 0; i < 3; i++) begin
         s2_dp_in[i] = s1_d_ff[i] * $signed({1'b0, s2_pq_w});
      end
      s2_side_in            = s1_side_ff;
      s2_side_in.use_static = s2_zero_w || (s2_bad_w && s1_cas_ff);
      s2_side_in.dyn_hit    = !s2_zero_w && !s2_bad_w;
      s2_side_in.pq         = s2_pq_w;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_dp_ff   <= s2_dp_in;
         s2_o_ff    <= s1_o_ff;
         s2_s_ff    <= s1_s_ff;
         s2_rr_ff   <= s1_rr_ff;
         s2_side_ff <= s2_side_in;
      end
   end

   // stage 3: perpendicular component per axis, magnitude truncated to Q16.16
   logic signed [52:0] s3_q_w [3];
   logic [52:0]        s3_abs_w [3];
   logic [31:0]        s3_m_in [3];
   logic [31:0]        s3_m_ff [3];
   logic               s3_far_in, s3_far_ff;
   logic [63:0]        s3_s_ff, s3_rr_ff;
   sshd_side_type      s3_side_ff;

   always_comb begin
      s3_far_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         s3_q_w[i]   = 53'($signed({s2_o_ff[i], 16'b0})) - 53'(s2_dp_ff[i]);
         s3_abs_w[i] = s3_q_w[i][52] ? 53'(-s3_q_w[i]) : s3_q_w[i];
         s3_m_in[i]  = s3_abs_w[i][47:16];
         // magnitude at or above 2^32 can never be inside the radius sum
         if (s3_abs_w[i][52:48] != '0) begin
            s3_far_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_m_ff    <= s3_m_in;
         s3_far_ff  <= s3_far_in;
         s3_s_ff    <= s2_s_ff;
         s3_rr_ff   <= s2_rr_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // stage 4: squares of the perpendicular magnitudes
   logic [63:0]   s4_sq_in [3];
   logic [63:0]   s4_sq_ff [3];
   logic          s4_far_ff;
   logic [63:0]   s4_s_ff, s4_rr_ff;
   sshd_side_type s4_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_sq_in[i] = s3_m_ff[i] * s3_m_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_sq_ff   <= s4_sq_in;
         s4_far_ff  <= s3_far_ff;
         s4_s_ff    <= s3_s_ff;
         s4_rr_ff   <= s3_rr_ff;
         s4_side_ff <= s3_side_ff;
      end
   end

   // stage 5: squared closest distance, kept exact instead of saturating
   logic [65:0]   s5_dsq_in, s5_dsq_ff;
   logic          s5_far_ff;
   logic [63:0]   s5_s_ff, s5_rr_ff;
   sshd_side_type s5_side_ff;

   assign s5_dsq_in = 66'(s4_sq_ff[0]) + 66'(s4_sq_ff[1]) + 66'(s4_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_dsq_ff  <= s5_dsq_in;
         s5_far_ff  <= s4_far_ff;
         s5_s_ff    <= s4_s_ff;
         s5_rr_ff   <= s4_rr_ff;
         s5_side_ff <= s4_side_ff;
      end
   end

   // stage 6: swept hit decision and the one radicand the root unit needs
   logic [63:0]   s6_rad_in, s6_rad_ff;
   sshd_side_type s6_side_in, s6_side_ff;

   always_comb begin
      s6_side_in         = s5_side_ff;
      s6_side_in.dyn_hit = s5_side_ff.dyn_hit && !s5_far_ff
                           && (s5_dsq_ff < {2'b0, s5_rr_ff});
      s6_rad_in          = s5_side_ff.use_static ? s5_s_ff : (s5_rr_ff - s5_dsq_ff[63:0]);
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_rad_ff  <= s6_rad_in;
         s6_side_ff <= s6_side_in;
      end
   end

   // root stages: 32 digit steps, two per stage, trial bit fixed per step
   sshd_root_type rt_in [ROOT_STAGES];
   sshd_root_type rt_ff [ROOT_STAGES];
   sshd_side_type rt_side_ff [ROOT_STAGES];

   for (genvar j = 0; j < ROOT_STAGES; j++) begin : g_root
      sshd_root_type prev_w;
      sshd_root_type mid_w;

      always_comb begin
         if (j == 0) begin
            prev_w.rem  = s6_rad_ff;
            prev_w.root = '0;
         end else begin
            prev_w = rt_ff[(j == 0) ? 0 : j - 1];
         end
         mid_w    = root_step(prev_w, 64'd1 << (62 - 4 * j));
         rt_in[j] = root_step(mid_w, 64'd1 << (60 - 4 * j));
      end

      always_ff @(posedge clock) begin
         if (adv[FRONT_STAGES + j]) begin
            rt_ff[j]      <= rt_in[j];
            rt_side_ff[j] <= (j == 0) ? s6_side_ff : rt_side_ff[(j == 0) ? 0 : j - 1];
         end
      end
   end

   // output register: static overlap or swept contact distance
   sshd_side_type last_side_w;
   logic [32:0]   root_w;
   logic [33:0]   gap_w;
   logic          hit_in, hit_ff;
   logic [30:0]   dist_in, dist_ff;

   always_comb begin
      last_side_w = rt_side_ff[ROOT_STAGES-1];
      root_w      = rt_ff[ROOT_STAGES-1].root[32:0];
      gap_w       = {1'b0, last_side_w.pq} - {1'b0, root_w};
      hit_in      = 1'b0;
      dist_in     = '0;
      if (last_side_w.use_static) begin
         if (root_w < {1'b0, last_side_w.radsum}) begin
            hit_in = 1'b1;
            if (last_side_w.report) begin
               dist_in = (root_w > {2'b0, DIST_MAX}) ? DIST_MAX : root_w[30:0];
            end
         end
      end else if (last_side_w.dyn_hit) begin
         hit_in = 1'b1;
         // contact before the start or past the end reports zero
         if (!gap_w[33] && (gap_w[32:0] <= {2'b0, last_side_w.move})) begin
            dist_in = gap_w[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NUM_STAGES-1]) begin
         hit_ff  <= hit_in;
         dist_ff <= dist_in;
      end
   end

   assign rsp_hit          = hit_ff;
   assign rsp_hit_distance = dist_ff;

endmodule
